// ----- rtl/core/mbrc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the Modbus RTU reply checker.
// Depends on nothing; every module of the checker imports it.
`timescale 1ns / 1ps

package mbrc_pkg;

  // Bytes of one frame that enter the CRC and the length
  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned FRAME_LEN_W     = 9;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_RESIDUE  = 16'h0000;
  localparam logic [6:0]  MAX_REGS     = 7'd125;
  localparam int unsigned MIN_FRAME    = 4;
  // Address, function and byte count ahead of the data, CRC after it
  localparam int unsigned HDR_CRC_BYTES = 5;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SLAVE_ADDRESS     = 2'd0,
    CFG_EXPECTED_FUNCTION = 2'd1,
    CFG_BYTE_COUNT_CHECK  = 2'd2,
    CFG_REGISTER_COUNT    = 2'd3
  } cfg_index_e;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LENGTH    = 3'd1,
    ST_ADDRESS   = 3'd2,
    ST_EXCEPTION = 3'd3,
    ST_FUNCTION  = 3'd4,
    ST_CRC       = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [6:0] expected_function;
    logic       byte_count_check;
    logic [6:0] register_count;
  } cfg_t;

  // Frame state after the current byte has been taken in
  typedef struct packed {
    logic [15:0]      crc;
    logic [POS_W-1:0] pos;
    logic [7:0]       first_byte;
    logic [7:0]       second_byte;
    logic [7:0]       third_byte;
  } frame_t;

  // Reflected CRC-16, one byte, bit by bit
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mbrc_cfg.sv -----
// Configuration register file of the Modbus RTU reply checker.
// Depends on mbrc_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module mbrc_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  output mbrc_pkg::cfg_t   cfg_o
);
  import mbrc_pkg::*;

  cfg_t cfg_q;

  // Always ready: every write is taken and lands in the addressed register
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Hold the registers, update the addressed one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address     <= 8'd1;
      cfg_q.expected_function <= 7'd3;
      cfg_q.byte_count_check  <= 1'b1;
      cfg_q.register_count    <= 7'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SLAVE_ADDRESS:     cfg_q.slave_address     <= cfg_data_i;
        CFG_EXPECTED_FUNCTION: cfg_q.expected_function <= cfg_data_i[6:0];
        CFG_BYTE_COUNT_CHECK:  cfg_q.byte_count_check  <= cfg_data_i[0];
        CFG_REGISTER_COUNT:    cfg_q.register_count    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/mbrc_frame.sv -----
// Frame accumulator: running CRC, byte position and the three header bytes.
// Depends on mbrc_pkg for the CRC update and the frame_t struct.
`timescale 1ns / 1ps

module mbrc_frame (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output mbrc_pkg::frame_t frame_o
);
  import mbrc_pkg::*;

  frame_t frame_q;
  frame_t frame_d;
  frame_t frame_upd;
  logic   keep;

  // Take the byte only while fewer than MAX_FRAME_BYTES bytes have been kept
  assign keep = (frame_q.pos < POS_W'(MAX_FRAME_BYTES));

  always_comb begin
    frame_upd = frame_q;
    if (keep) begin
      frame_upd.crc = crc16_byte(frame_q.crc, byte_i);
      frame_upd.pos = frame_q.pos + POS_W'(1);
      if (frame_q.pos == POS_W'(0)) begin
        frame_upd.first_byte = byte_i;
      end
      if (frame_q.pos == POS_W'(1)) begin
        frame_upd.second_byte = byte_i;
      end
      if (frame_q.pos == POS_W'(2)) begin
        frame_upd.third_byte = byte_i;
      end
    end
  end

  assign frame_o = frame_upd;

  // Reload CRC and position once the frame ends, keep the header bytes
  always_comb begin
    frame_d = frame_upd;
    if (last_i) begin
      frame_d.crc = CRC_INIT;
      frame_d.pos = '0;
    end
  end

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q.crc         <= CRC_INIT;
      frame_q.pos         <= '0;
      frame_q.first_byte  <= 8'h00;
      frame_q.second_byte <= 8'h00;
      frame_q.third_byte  <= 8'h00;
    end else if (advance_i) begin
      frame_q <= frame_d;
    end
  end

endmodule

// ----- rtl/core/mbrc_status.sv -----
// Frame-end status decision: ordered checks over the finished frame state.
// Depends on mbrc_pkg for cfg_t, frame_t and the status codes.
`timescale 1ns / 1ps

module mbrc_status (
  input  mbrc_pkg::cfg_t    cfg_i,
  input  mbrc_pkg::frame_t  frame_i,
  output mbrc_pkg::status_e status_o
);
  import mbrc_pkg::*;

  localparam int unsigned CMP_W = (POS_W > 9) ? POS_W : 9;

  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] need_len;
  logic [7:0]       data_bytes;
  logic             count_bad;

  assign len        = CMP_W'(frame_i.pos);
  assign data_bytes = {cfg_i.register_count, 1'b0};
  assign need_len   = CMP_W'(data_bytes) + CMP_W'(HDR_CRC_BYTES);
  assign count_bad  = (cfg_i.register_count == 7'd0) ||
                      (cfg_i.register_count > MAX_REGS);

  // First failing check wins
  always_comb begin
    priority if (len < CMP_W'(MIN_FRAME)) begin
      status_o = ST_LENGTH;
    end else if (frame_i.first_byte != cfg_i.slave_address) begin
      status_o = ST_ADDRESS;
    end else if (frame_i.second_byte[7]) begin
      status_o = ST_EXCEPTION;
    end else if (frame_i.second_byte[6:0] != cfg_i.expected_function) begin
      status_o = ST_FUNCTION;
    end else if (frame_i.crc != CRC_RESIDUE) begin
      status_o = ST_CRC;
    end else if (cfg_i.byte_count_check &&
                 (count_bad || (len < need_len) || (frame_i.third_byte != data_bytes))) begin
      status_o = ST_LENGTH;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

// ----- rtl/core/modbus_rtu_response_checker.sv -----
// Top level of the Modbus RTU reply checker: input register, frame state, result register.
// Depends on mbrc_pkg, mbrc_cfg, mbrc_frame and mbrc_status.
`timescale 1ns / 1ps

// Feed the reply one byte per transaction with frame_end_i high on the last byte. The
// checker takes one byte every cycle while in_stall_o is low; the byte is registered,
// then the CRC-16 update (reflected, polynomial 0xA001, init 0xFFFF) and, on the last
// byte, the ordered status checks run into the result register. Only the frame's last
// byte produces a result: status_o (0 ok, 1 length, 2 address, 3 exception, 4 function,
// 5 crc) with frame_length_o, the number of bytes kept (at most 256; later bytes are
// ignored). Input is stalled only when a frame-end byte waits behind an untaken result.
// Configuration writes are always accepted and must be made while no frame is in flight.
module modbus_rtu_response_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [8:0] frame_length_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import mbrc_pkg::*;

  cfg_t    cfg;
  frame_t  frame;
  status_e status;

  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   in_last_q;
  logic                   out_vld_q;
  status_e                status_q;
  logic [FRAME_LEN_W-1:0] len_q;
  logic                   out_free;
  logic                   advance;
  logic                   in_take;

  // Result slot is free when empty or being taken this cycle
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!in_last_q || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  mbrc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbrc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .frame_o   (frame)
  );

  mbrc_status u_status (
    .cfg_i    (cfg),
    .frame_i  (frame),
    .status_o (status)
  );

  // Input register: load a new transaction, drop the old one once it advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
      in_last_q <= frame_end_i;
    end
  end

  // Result register: fill on frame end, clear when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      status_q <= status;
      len_q    <= FRAME_LEN_W'(frame.pos);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign frame_length_o = len_q;

endmodule
